// ===== design/btr_pkg.sv =====
// Shared types and constants of the bitmap text renderer.
// No dependencies; the top level bitmap_text_renderer refers to it by scoped names.
package btr_pkg;

   localparam int FIRST_PRINTABLE = 32;
   localparam int CELL            = 8;
   localparam int TAB_ADVANCE     = CELL * 4;
   localparam int IMAGE_LIMIT     = 4096;
   localparam int GLYPH_BITS      = CELL * CELL;
   localparam int SCAN_BITS       = 6;
   localparam int SIZE_BITS       = 13;
   localparam int COLOR_BITS      = 24;
   localparam int PIXEL_BITS      = 12;
   localparam int CSR_INDEX_BITS  = 2;

   localparam logic [7:0] CODE_TAB     = 8'd9;
   localparam logic [7:0] CODE_NEWLINE = 8'd10;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DRAW_COLOR   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PREP = 4'b0010,
      ST_MASK = 4'b0100,
      ST_SCAN = 4'b1000
   } state_type;

endpackage

// ===== design/btr_req_if.sv =====
// Request channel of the bitmap text renderer: glyph loads and characters.
// Self-contained; used by the top level bitmap_text_renderer.
interface btr_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic [6:0]         glyph_index;
   logic [63:0]        glyph_bits;
   logic [7:0]         char_code;
   logic               first_of_string;
   logic signed [15:0] origin_x;
   logic signed [15:0] origin_y;

   modport source (
      output valid, operation, glyph_index, glyph_bits, char_code,
             first_of_string, origin_x, origin_y,
      input  ready
   );
   modport sink (
      input  valid, operation, glyph_index, glyph_bits, char_code,
             first_of_string, origin_x, origin_y,
      output ready
   );
endinterface

// ===== design/btr_rsp_if.sv =====
// Response channel of the bitmap text renderer: one pixel write per transfer.
// Self-contained; used by the top level bitmap_text_renderer.
interface btr_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] pixel_column;
   logic [11:0] pixel_row;
   logic [23:0] pixel_color;
   logic        last_of_char;

   modport source (
      output valid, pixel_column, pixel_row, pixel_color, last_of_char,
      input  ready
   );
   modport sink (
      input  valid, pixel_column, pixel_row, pixel_color, last_of_char,
      output ready
   );
endinterface

// ===== design/bitmap_text_renderer.sv =====
// Bitmap text renderer top level: font store, text cursor and glyph scan sequencer.
// Depends on btr_pkg, btr_req_if and btr_rsp_if.
//
// A glyph load, a newline, a tab or a code without a glyph is taken in the idle state, and the
// next request transfer can follow in the next cycle. A printable character passes through
// the setup steps font store read, row flip and clip mask, then scans the glyph bits up to
// its last visible set bit and returns to idle. The single scan step tests one glyph bit and
// forms one pixel address per cycle while the pixel output is not stalled. The font store
// resets to blank glyphs through per-slot valid bits, so no clearing pass is needed.
module bitmap_text_renderer #(
   parameter int GLYPH_COUNT = 96,
   parameter int COORD_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [btr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [btr_pkg::COLOR_BITS-1:0]       csr_write_data,
   btr_req_if.sink                              req,
   btr_rsp_if.source                            rsp
);

   localparam int GI_BITS = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
   localparam int WB      = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
   localparam int C       = COORD_BITS;
   localparam int SB      = btr_pkg::SIZE_BITS;
   localparam int PB      = btr_pkg::PIXEL_BITS;
   localparam int GB      = btr_pkg::GLYPH_BITS;
   localparam int NB      = btr_pkg::SCAN_BITS;
   localparam logic signed [WB-1:0] COORD_MAX = (WB'(1) <<< (C - 1)) - WB'(1);
   localparam logic signed [WB-1:0] COORD_MIN = -COORD_MAX - WB'(1);
   localparam logic signed [WB-1:0] CELL_W    = WB'(btr_pkg::CELL);
   localparam logic signed [WB-1:0] TAB_W     = WB'(btr_pkg::TAB_ADVANCE);
   localparam logic [SB-1:0]        LIMIT     = SB'(btr_pkg::IMAGE_LIMIT);

   function automatic logic signed [C-1:0] coord_sat(input logic signed [WB-1:0] v);
      logic signed [C-1:0] r;
      if (v > COORD_MAX) begin
         r = COORD_MAX[C-1:0];
      end else if (v < COORD_MIN) begin
         r = COORD_MIN[C-1:0];
      end else begin
         r = v[C-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [WB-1:0] coord_ext(input logic signed [C-1:0] v);
      return $signed({{(WB-C){v[C-1]}}, v});
   endfunction

   function automatic logic [SB-1:0] size_clamp(input logic [SB-1:0] s);
      return (s > LIMIT) ? LIMIT : s;
   endfunction

   // Configuration registers.
   logic [SB-1:0]                    cfg_width_ff, cfg_height_ff;
   logic [btr_pkg::COLOR_BITS-1:0]   cfg_color_ff;

   // Font store with per-slot valid bits.
   logic [GB-1:0]                    font_mem [GLYPH_COUNT];
   logic [GLYPH_COUNT-1:0]           font_valid_ff;
   logic [GB-1:0]                    rd_glyph_ff;
   logic                             rd_valid_ff;

   // Cursor and per-character working registers.
   btr_pkg::state_type               state_ff, state_in;
   logic signed [C-1:0]              cursor_x_ff, cursor_x_in;
   logic signed [C-1:0]              cursor_y_ff, cursor_y_in;
   logic signed [C-1:0]              line_x_ff, line_x_in;
   logic signed [C-1:0]              draw_x_ff, draw_y_ff;
   logic [SB-1:0]                    img_w_ff, img_h_ff;
   logic [btr_pkg::COLOR_BITS-1:0]   color_ff;
   logic signed [WB-1:0]             top_ff, top_in;
   logic [GB-1:0]                    glyph_ff, glyph_in;
   logic [GB-1:0]                    mask_ff, mask_in;
   logic [NB-1:0]                    scan_idx_ff, scan_idx_in;

   // Pixel output register.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [PB-1:0]                    rsp_col_ff, rsp_row_ff;
   logic [btr_pkg::COLOR_BITS-1:0]   rsp_color_ff;
   logic                             rsp_last_ff, rsp_last_in;
   logic                             rsp_load;

   logic                             req_fire, is_render, printable, rd_enable;
   logic [7:0]                       code_off;
   logic [GI_BITS-1:0]               rd_addr, wr_addr;
   logic                             wr_enable;
   logic signed [C-1:0]              x_eff, y_eff, line_eff;
   logic signed [WB-1:0]             col_sum, row_sum, vis_row, vis_col;
   logic [btr_pkg::CELL-1:0]         row_vis, col_vis;

   assign req.ready = (state_ff == btr_pkg::ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign is_render = (req.operation == btr_pkg::OP_RENDER);
   assign code_off  = req.char_code - 8'(btr_pkg::FIRST_PRINTABLE);
   assign printable = (req.char_code >= 8'(btr_pkg::FIRST_PRINTABLE))
                      && ({1'b0, code_off} < 9'(GLYPH_COUNT));
   assign rd_enable = req_fire && is_render && printable;
   assign rd_addr   = code_off[GI_BITS-1:0];
   assign wr_enable = req_fire && !is_render && ({1'b0, req.glyph_index} < 8'(GLYPH_COUNT));
   assign wr_addr   = GI_BITS'(req.glyph_index);

   assign x_eff    = req.first_of_string
                     ? coord_sat($signed({{(WB-16){req.origin_x[15]}}, req.origin_x}))
                     : cursor_x_ff;
   assign y_eff    = req.first_of_string
                     ? coord_sat($signed({{(WB-16){req.origin_y[15]}}, req.origin_y}))
                     : cursor_y_ff;
   assign line_eff = req.first_of_string ? x_eff : line_x_ff;

   assign col_sum = coord_ext(draw_x_ff) + $signed(WB'(scan_idx_ff[2:0]));
   assign row_sum = top_ff + $signed(WB'(scan_idx_ff[NB-1:3]));

   always_comb begin
      for (int i = 0; i < btr_pkg::CELL; i++) begin
         vis_row    = top_ff + $signed(WB'(i));
         vis_col    = coord_ext(draw_x_ff) + $signed(WB'(i));
         row_vis[i] = (vis_row >= 0) && (vis_row < $signed(WB'(img_h_ff)));
         col_vis[i] = (vis_col >= 0) && (vis_col < $signed(WB'(img_w_ff)));
      end
   end

   always_comb begin
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      line_x_in    = line_x_ff;
      state_in     = state_ff;
      top_in       = top_ff;
      glyph_in     = glyph_ff;
      mask_in      = mask_ff;
      scan_idx_in  = scan_idx_ff;
      rsp_load     = 1'b0;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         btr_pkg::ST_IDLE: begin
            if (req_fire && is_render) begin
               cursor_y_in = y_eff;
               line_x_in   = line_eff;
               if (req.char_code == btr_pkg::CODE_NEWLINE) begin
                  cursor_x_in = line_eff;
                  cursor_y_in = coord_sat(coord_ext(y_eff) - CELL_W);
               end else if (req.char_code == btr_pkg::CODE_TAB) begin
                  cursor_x_in = coord_sat(coord_ext(x_eff) + TAB_W);
               end else begin
                  cursor_x_in = coord_sat(coord_ext(x_eff) + CELL_W);
               end
               if (printable) begin
                  state_in = btr_pkg::ST_PREP;
               end
            end
         end
         btr_pkg::ST_PREP: begin
            top_in   = $signed(WB'(img_h_ff)) - CELL_W - coord_ext(draw_y_ff);
            glyph_in = rd_valid_ff ? rd_glyph_ff : '0;
            state_in = btr_pkg::ST_MASK;
         end
         btr_pkg::ST_MASK: begin
            for (int r = 0; r < btr_pkg::CELL; r++) begin
               for (int c = 0; c < btr_pkg::CELL; c++) begin
                  mask_in[r*btr_pkg::CELL+c] = glyph_ff[r*btr_pkg::CELL+c]
                                               && row_vis[r] && col_vis[c];
               end
            end
            scan_idx_in = '0;
            state_in    = btr_pkg::ST_SCAN;
         end
         btr_pkg::ST_SCAN: begin
            if (mask_ff == '0) begin
               state_in = btr_pkg::ST_IDLE;
            end else if (mask_ff[scan_idx_ff]) begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_load    = 1'b1;
                  mask_in     = mask_ff & ~(GB'(1) << scan_idx_ff);
                  rsp_last_in = (mask_in == '0);
                  scan_idx_in = scan_idx_ff + NB'(1);
               end
            end else begin
               scan_idx_in = scan_idx_ff + NB'(1);
            end
         end
         default: begin
            state_in = btr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= SB'(640);
         cfg_height_ff <= SB'(480);
         cfg_color_ff  <= 24'hFFFFFF;
      end else if (csr_write_enable) begin
         priority if (csr_index == btr_pkg::REG_IMAGE_WIDTH) begin
            cfg_width_ff <= csr_write_data[SB-1:0];
         end else if (csr_index == btr_pkg::REG_IMAGE_HEIGHT) begin
            cfg_height_ff <= csr_write_data[SB-1:0];
         end else if (csr_index == btr_pkg::REG_DRAW_COLOR) begin
            cfg_color_ff <= csr_write_data;
         end else begin
            cfg_color_ff <= cfg_color_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_enable) begin
         font_mem[wr_addr] <= req.glyph_bits;
      end
      if (rd_enable) begin
         rd_glyph_ff <= font_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         font_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         if (wr_enable) begin
            font_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_enable) begin
            rd_valid_ff <= font_valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= btr_pkg::ST_IDLE;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         line_x_ff    <= '0;
         mask_ff      <= '0;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         line_x_ff    <= line_x_in;
         mask_ff      <= mask_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff   <= top_in;
      glyph_ff <= glyph_in;
      if (rd_enable) begin
         draw_x_ff <= x_eff;
         draw_y_ff <= y_eff;
         img_w_ff  <= size_clamp(cfg_width_ff);
         img_h_ff  <= size_clamp(cfg_height_ff);
         color_ff  <= cfg_color_ff;
      end
      if (rsp_load) begin
         rsp_col_ff   <= col_sum[PB-1:0];
         rsp_row_ff   <= row_sum[PB-1:0];
         rsp_color_ff <= color_ff;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.pixel_column = rsp_col_ff;
   assign rsp.pixel_row    = rsp_row_ff;
   assign rsp.pixel_color  = rsp_color_ff;
   assign rsp.last_of_char = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      rd_enable |=> state_ff == btr_pkg::ST_PREP)
      else $error("Printable character did not start the glyph sequence.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == btr_pkg::ST_SCAN && mask_ff == '0) |=> state_ff == btr_pkg::ST_IDLE)
      else $error("Scan did not finish once no visible pixel remained.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> mask_ff == '0)
      else $error("Last pixel of a character sent while pixels remain.");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == btr_pkg::ST_SCAN |-> (mask_ff & ~glyph_ff) == '0)
      else $error("Visible mask holds a bit that the glyph does not set.");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(state_ff == btr_pkg::ST_SCAN))
      else $error("Pixel transfer offered outside the glyph scan.");

endmodule

// ===== bench/bitmap_text_renderer_tb.sv =====
// Self-checking testbench for the bitmap text renderer: glyph loads, cursor moves and pixel writes.
// Uses btr_pkg, btr_req_if, btr_rsp_if and the top level bitmap_text_renderer.
// A shadow font store, cursor and register set predict every pixel write.
module bitmap_text_renderer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import btr_pkg::*;

   localparam int GLYPH_COUNT   = 96;
   localparam int COORD_BITS    = 16;
   localparam int COORD_MAX     = (1 << (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN     = -COORD_MAX - 1;
   localparam int SETTLE_CYCLES = 100;
   localparam int LONG_HOLD     = 600;
   localparam int CYCLE_LIMIT   = 2_000_000;

   typedef struct packed {
      logic               operation;
      logic [6:0]         glyph_index;
      logic [63:0]        glyph_bits;
      logic [7:0]         char_code;
      logic               first_of_string;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
   } text_request_t;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_column;
      logic [PIXEL_BITS-1:0] pixel_row;
      logic [COLOR_BITS-1:0] pixel_color;
      logic                  last_of_char;
   } pixel_write_t;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [COLOR_BITS-1:0]     csr_write_data;

   btr_req_if req_ch();
   btr_rsp_if rsp_ch();

   bitmap_text_renderer #(
      .GLYPH_COUNT (GLYPH_COUNT),
      .COORD_BITS  (COORD_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req              (req_ch),
      .rsp              (rsp_ch)
   );

   logic [63:0]           font_shadow [GLYPH_COUNT];
   int                    cursor_x;
   int                    cursor_y;
   int                    line_start_x;
   logic [SIZE_BITS-1:0]  image_width;
   logic [SIZE_BITS-1:0]  image_height;
   logic [COLOR_BITS-1:0] draw_color;

   pixel_write_t expected_pixels [$];
   int           loaded_codes [$];

   int send_gap_pct;
   int recv_stall_pct;
   int hold_ticket;
   int error_count;
   int pixels_checked;
   int requests_sent;
   int settings_applied;
   int cycle_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int clamp_coord(longint value);
      if (value > COORD_MAX) return COORD_MAX;
      if (value < COORD_MIN) return COORD_MIN;
      return int'(value);
   endfunction

   function automatic void render_expected_pixels(text_request_t rq);
      logic [63:0]  glyph;
      int           code;
      int           width;
      int           height;
      int           top;
      int           row;
      int           col;
      pixel_write_t held;
      bit           have_held;
      have_held = 1'b0;
      code = rq.char_code;
      if (rq.operation == OP_LOAD) begin
         if (rq.glyph_index < GLYPH_COUNT) font_shadow[rq.glyph_index] = rq.glyph_bits;
         return;
      end
      if (rq.first_of_string) begin
         cursor_x = clamp_coord($signed(rq.origin_x));
         cursor_y = clamp_coord($signed(rq.origin_y));
         line_start_x = cursor_x;
      end
      if (rq.char_code == CODE_NEWLINE) begin
         cursor_x = line_start_x;
         cursor_y = clamp_coord(longint'(cursor_y) - CELL);
      end else if (rq.char_code == CODE_TAB) begin
         cursor_x = clamp_coord(longint'(cursor_x) + TAB_ADVANCE);
      end else begin
         if (code >= FIRST_PRINTABLE && code - FIRST_PRINTABLE < GLYPH_COUNT) begin
            glyph  = font_shadow[code - FIRST_PRINTABLE];
            width  = (image_width > IMAGE_LIMIT) ? IMAGE_LIMIT : int'(image_width);
            height = (image_height > IMAGE_LIMIT) ? IMAGE_LIMIT : int'(image_height);
            top    = height - CELL - cursor_y;
            for (int r = 0; r < CELL; r++) begin
               row = top + r;
               if (row >= 0 && row < height) begin
                  for (int c = 0; c < CELL; c++) begin
                     col = cursor_x + c;
                     if (glyph[r * CELL + c] && col >= 0 && col < width) begin
                        if (have_held) expected_pixels.push_back(held);
                        held.pixel_column = col[PIXEL_BITS-1:0];
                        held.pixel_row    = row[PIXEL_BITS-1:0];
                        held.pixel_color  = draw_color;
                        held.last_of_char = 1'b0;
                        have_held = 1'b1;
                     end
                  end
               end
            end
            if (have_held) begin
               held.last_of_char = 1'b1;
               expected_pixels.push_back(held);
            end
         end
         cursor_x = clamp_coord(longint'(cursor_x) + CELL);
      end
   endfunction

   function automatic text_request_t random_request();
      text_request_t rq;
      rq.operation       = 1'($urandom_range(0, 1));
      rq.glyph_index     = 7'($urandom_range(0, 127));
      rq.glyph_bits      = {$urandom, $urandom};
      rq.char_code       = 8'($urandom_range(0, 255));
      rq.first_of_string = 1'($urandom_range(0, 1));
      rq.origin_x        = 16'($urandom_range(0, 65535));
      rq.origin_y        = 16'($urandom_range(0, 65535));
      return rq;
   endfunction

   function automatic text_request_t glyph_load(int slot, logic [63:0] bits);
      text_request_t rq;
      rq = random_request();
      rq.operation   = OP_LOAD;
      rq.glyph_index = 7'(slot);
      rq.glyph_bits  = bits;
      return rq;
   endfunction

   function automatic text_request_t char_request(int code, bit first, int x, int y);
      text_request_t rq;
      rq = random_request();
      rq.operation       = OP_RENDER;
      rq.char_code       = 8'(code);
      rq.first_of_string = first;
      rq.origin_x        = 16'(x);
      rq.origin_y        = 16'(y);
      return rq;
   endfunction

   task automatic send_request(text_request_t rq);
      int gap;
      if (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
         gap = $urandom_range(1, 14);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.operation       <= rq.operation;
      req_ch.glyph_index     <= rq.glyph_index;
      req_ch.glyph_bits      <= rq.glyph_bits;
      req_ch.char_code       <= rq.char_code;
      req_ch.first_of_string <= rq.first_of_string;
      req_ch.origin_x        <= rq.origin_x;
      req_ch.origin_y        <= rq.origin_y;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      render_expected_pixels(rq);
      if (rq.operation == OP_LOAD && rq.glyph_index < GLYPH_COUNT) begin
         loaded_codes.push_back(rq.glyph_index + FIRST_PRINTABLE);
      end
      requests_sent++;
   endtask

   task automatic finish_outstanding();
      req_ch.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(int unsigned width, int unsigned height, logic [23:0] color);
      finish_outstanding();
      csr_write_enable <= 1'b1;
      csr_index        <= REG_IMAGE_WIDTH;
      csr_write_data   <= COLOR_BITS'(width[SIZE_BITS-1:0]);
      image_width      = width[SIZE_BITS-1:0];
      @(posedge clock);
      csr_index        <= REG_IMAGE_HEIGHT;
      csr_write_data   <= COLOR_BITS'(height[SIZE_BITS-1:0]);
      image_height     = height[SIZE_BITS-1:0];
      @(posedge clock);
      csr_index        <= REG_DRAW_COLOR;
      csr_write_data   <= color;
      draw_color       = color;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_applied++;
   endtask

   task automatic run_text_items(int count);
      text_request_t rq;
      int            sent;
      int            kind;
      int            len;
      int            span_x;
      int            span_y;
      sent   = 0;
      span_x = (image_width > IMAGE_LIMIT) ? IMAGE_LIMIT : int'(image_width);
      span_y = (image_height > IMAGE_LIMIT) ? IMAGE_LIMIT : int'(image_height);
      while (sent < count) begin
         kind = $urandom_range(0, 99);
         if (kind < 15) begin
            rq = random_request();
            rq.operation = OP_LOAD;
            if ($urandom_range(0, 9) != 0) rq.glyph_index = 7'($urandom_range(0, GLYPH_COUNT - 1));
            case ($urandom_range(0, 2))
               0: begin
                  rq.glyph_bits = rq.glyph_bits & {$urandom, $urandom};
               end
               1: begin
                  rq.glyph_bits = rq.glyph_bits | {$urandom, $urandom};
               end
               default: begin
               end
            endcase
            send_request(rq);
            sent++;
         end else if (kind < 90) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
               rq = random_request();
               rq.operation       = OP_RENDER;
               rq.first_of_string = (k == 0);
               if (k == 0) begin
                  rq.origin_x = 16'(int'($urandom_range(0, span_x + 16)) - 8);
                  rq.origin_y = 16'(int'($urandom_range(0, span_y + 16)) - 8);
               end
               case ($urandom_range(0, 11))
                  0: begin
                     rq.char_code = CODE_NEWLINE;
                  end
                  1: begin
                     rq.char_code = CODE_TAB;
                  end
                  2, 3, 4: begin
                     rq.char_code = 8'($urandom_range(FIRST_PRINTABLE,
                                                      FIRST_PRINTABLE + GLYPH_COUNT - 1));
                  end
                  default: begin
                     if (loaded_codes.size() != 0) begin
                        rq.char_code =
                           8'(loaded_codes[$urandom_range(0, loaded_codes.size() - 1)]);
                     end
                  end
               endcase
               send_request(rq);
            end
            sent += len;
         end else begin
            send_request(random_request());
            sent++;
         end
      end
   endtask

   task automatic test_blank_font();
      send_request(char_request(65, 1'b1, 10, 10));
   endtask

   task automatic test_glyph_loads();
      send_request(glyph_load(0, '1));
      send_request(glyph_load(GLYPH_COUNT - 1, 64'h55AA_55AA_55AA_55AA));
      send_request(glyph_load(33, 64'h8142_2418_1824_4281));
      send_request(glyph_load(GLYPH_COUNT, '1));
      send_request(glyph_load(127, '1));
   endtask

   task automatic test_character_codes();
      send_request(char_request(32, 1'b1, 0, 0));
      send_request(char_request(127, 1'b0, 0, 0));
      send_request(char_request(65, 1'b0, 0, 0));
      send_request(char_request(CODE_NEWLINE, 1'b0, 0, 0));
      send_request(char_request(CODE_TAB, 1'b0, 0, 0));
      send_request(char_request(0, 1'b0, 0, 0));
      send_request(char_request(31, 1'b0, 0, 0));
      send_request(char_request(128, 1'b0, 0, 0));
      send_request(char_request(255, 1'b0, 0, 0));
      send_request(char_request(32, 1'b0, 0, 0));
   endtask

   task automatic test_coordinate_limits();
      send_request(char_request(CODE_TAB, 1'b1, 32767, 32767));
      send_request(char_request(32, 1'b0, 0, 0));
      send_request(char_request(CODE_NEWLINE, 1'b1, -32768, -32768));
      send_request(char_request(32, 1'b1, -4, 476));
      send_request(char_request(32, 1'b1, 636, 2));
   endtask

   task automatic test_image_sizes();
      apply_settings(1, 1, 24'h000000);
      send_request(char_request(32, 1'b1, 0, -7));
      apply_settings(8191, 8191, 24'hA5A5A5);
      send_request(char_request(32, 1'b1, 4092, 0));
      apply_settings(0, 0, 24'h5A5A5A);
      send_request(char_request(32, 1'b1, 0, 0));
   endtask

   task automatic test_output_backpressure();
      apply_settings(64, 64, 24'($urandom));
      send_gap_pct = 0;
      hold_ticket++;
      for (int k = 0; k < 6; k++) begin
         send_request(char_request(32, 1'b1, CELL * k, 20));
      end
   endtask

   task automatic test_random_text();
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               apply_settings(64, 48, 24'($urandom));
            end
            1: begin
               apply_settings($urandom_range(8, 300), $urandom_range(8, 300), 24'($urandom));
            end
            2: begin
               apply_settings(IMAGE_LIMIT, IMAGE_LIMIT, 24'hFFFFFF);
            end
            3: begin
               apply_settings(1, 1, 24'h000000);
            end
            default: begin
               apply_settings($urandom_range(8, 300), $urandom_range(8, 300), 24'($urandom));
            end
         endcase
         send_gap_pct   = (phase == 1) ? 0 : 10 * $urandom_range(1, 4);
         recv_stall_pct = (phase == 1) ? 0 : 10 * $urandom_range(1, 4);
         run_text_items((phase == 3) ? 30 : 60);
      end
   endtask

   task automatic test_steady_stream();
      apply_settings(200, 120, 24'($urandom));
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      run_text_items(40);
   endtask

   initial begin : receiver
      int hold_seen;
      int hold_left;
      int stall_left;
      hold_seen    = 0;
      hold_left    = 0;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_ticket) begin
            hold_seen = hold_ticket;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (recv_stall_pct != 0 && $urandom_range(1, 100) <= recv_stall_pct) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : pixel_checker
      pixel_write_t wanted;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_pixels.size() == 0) begin
            $error("pixel write with none expected: column %0d, row %0d",
                   rsp_ch.pixel_column, rsp_ch.pixel_row);
            error_count++;
         end else begin
            wanted = expected_pixels.pop_front();
            pixels_checked++;
            if (rsp_ch.pixel_column !== wanted.pixel_column) begin
               $error("pixel_column: expected %0d, got %0d",
                      wanted.pixel_column, rsp_ch.pixel_column);
               error_count++;
            end
            if (rsp_ch.pixel_row !== wanted.pixel_row) begin
               $error("pixel_row: expected %0d, got %0d", wanted.pixel_row, rsp_ch.pixel_row);
               error_count++;
            end
            if (rsp_ch.pixel_color !== wanted.pixel_color) begin
               $error("pixel_color: expected %06h, got %06h",
                      wanted.pixel_color, rsp_ch.pixel_color);
               error_count++;
            end
            if (rsp_ch.last_of_char !== wanted.last_of_char) begin
               $error("last_of_char: expected %0b, got %0b",
                      wanted.last_of_char, rsp_ch.last_of_char);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("bitmap_text_renderer_tb: done, errors");
      $finish;
   end

   initial begin : sequencer
      reset                  = 1'b1;
      csr_write_enable       = 1'b0;
      csr_index              = REG_IMAGE_WIDTH;
      csr_write_data         = '0;
      req_ch.valid           = 1'b0;
      req_ch.operation       = OP_LOAD;
      req_ch.glyph_index     = '0;
      req_ch.glyph_bits      = '0;
      req_ch.char_code       = '0;
      req_ch.first_of_string = 1'b0;
      req_ch.origin_x        = '0;
      req_ch.origin_y        = '0;
      foreach (font_shadow[i]) font_shadow[i] = '0;
      cursor_x         = 0;
      cursor_y         = 0;
      line_start_x     = 0;
      image_width      = 640;
      image_height     = 480;
      draw_color       = 24'hFFFFFF;
      send_gap_pct     = 20;
      recv_stall_pct   = 20;
      hold_ticket      = 0;
      error_count      = 0;
      pixels_checked   = 0;
      requests_sent    = 0;
      settings_applied = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_blank_font();
      test_glyph_loads();
      test_character_codes();
      test_coordinate_limits();
      test_image_sizes();
      test_output_backpressure();
      test_random_text();
      test_steady_stream();
      finish_outstanding();

      $display("bitmap_text_renderer_tb: %0d requests transferred, %0d pixel writes checked",
               requests_sent, pixels_checked);
      $display("bitmap_text_renderer_tb: %0d register settings, zero to oversized image sizes",
               settings_applied);
      if (error_count == 0) begin
         $display("bitmap_text_renderer_tb: done, clean");
      end else begin
         $display("bitmap_text_renderer_tb: done, errors");
      end
      $finish;
   end

endmodule
